/* hdl/ffca_pkg.sv */
// shared types and constants of the first-fit chunk allocator
package ffca_pkg;

    // heap offset and chunk size widths
    localparam int ADDR_BITS = 16;
    localparam int SIZE_BITS = ADDR_BITS + 1;
    localparam logic [SIZE_BITS-1:0] HEAP_MAX = SIZE_BITS'(1) << ADDR_BITS;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // request word
    typedef struct packed {
        logic                 op;
        logic [SIZE_BITS-1:0] req_size;
        logic [ADDR_BITS-1:0] release_addr;
    } in_word_t;

    // response word
    typedef struct packed {
        logic [ADDR_BITS-1:0] result_addr;
        logic [1:0]           status;
    } out_word_t;

    // one chunk table entry as stored in the table memory
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
    } entry_t;

    // commands from controller to datapath
    typedef struct packed {
        logic init_write;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic write_slot;
        logic write_best;
        logic load_out;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic init_pending;
        logic scan_last;
        logic need_split;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/ffca_ram.sv */
// generic single write, single read memory with registered read data
module ffca_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ffca_datapath.sv */
// chunk table, scan evaluation, table updates and response register
module ffca_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffca_pkg::SIZE_BITS-1:0]  cfg_wdata,
    input  ffca_pkg::in_word_t              req_word,
    input  ffca_pkg::ctrl_cmd_t             cmd,
    output ffca_pkg::dp_status_t            sts,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output ffca_pkg::out_word_t             rsp_word
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = ffca_pkg::ADDR_BITS;
    localparam int SW = ffca_pkg::SIZE_BITS;
    localparam int EW = $bits(ffca_pkg::entry_t);

    // configuration and per-entry flags
    logic [SW-1:0]      heap_total_reg;
    logic               init_pending_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] used_reg, used_next;

    // captured request
    logic          op_reg;
    logic [SW-1:0] req_reg;
    logic [AW-1:0] addr_reg;

    // scan state
    logic [IDX_W-1:0] scan_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_tag_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [AW-1:0]    best_start_reg;
    logic [SW-1:0]    best_size_reg;
    logic             slot_found_reg;
    logic [IDX_W-1:0] slot_idx_reg;

    // response register
    logic                rsp_valid_reg;
    ffca_pkg::out_word_t rsp_word_reg;
    ffca_pkg::out_word_t res_word;

    // table memory
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ffca_pkg::entry_t ram_wdata;
    ffca_pkg::entry_t ram_rdata;
    logic [SW-1:0]    heap_eff;

    ffca_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // clamp of the heap size to 1 .. 2^ADDR_BITS
    always_comb
    begin
        if (heap_total_reg == '0)
        begin
            heap_eff = SW'(1);
        end
        else if (heap_total_reg > ffca_pkg::HEAP_MAX)
        begin
            heap_eff = ffca_pkg::HEAP_MAX;
        end
        else
        begin
            heap_eff = heap_total_reg;
        end
    end

    // table write mux
    always_comb
    begin
        ram_we    = cmd.init_write | cmd.write_slot | cmd.write_best;
        ram_waddr = '0;
        ram_wdata = '{start: '0, size: heap_eff};
        if (cmd.write_slot)
        begin
            ram_waddr = slot_idx_reg;
            ram_wdata = '{start: best_start_reg, size: req_reg};
        end
        else if (cmd.write_best)
        begin
            ram_waddr = best_idx_reg;
            ram_wdata = '{start: best_start_reg + req_reg[AW-1:0],
                          size: best_size_reg - req_reg};
        end
    end

    // evaluation of the entry whose read data is back
    logic rd_v, rd_u, hit, take;
    always_comb
    begin
        rd_v = valid_reg[rd_tag_reg];
        rd_u = used_reg[rd_tag_reg];
        if (op_reg == ffca_pkg::OP_ALLOC)
        begin
            hit  = rd_v && !rd_u && (ram_rdata.size >= req_reg);
            take = hit && (!best_found_reg || (ram_rdata.start < best_start_reg));
        end
        else
        begin
            hit  = rd_v && rd_u && (ram_rdata.start == addr_reg);
            take = hit && !best_found_reg;
        end
        take = take && rd_vld_reg;
    end

    // decision on the finished scan
    logic exact_fit, req_zero, need_split;
    always_comb
    begin
        exact_fit  = (best_size_reg == req_reg);
        req_zero   = (req_reg == '0);
        need_split = 1'b0;
        res_word   = '{result_addr: '0, status: ffca_pkg::ST_OK};
        if (op_reg == ffca_pkg::OP_FREE)
        begin
            if (!best_found_reg)
            begin
                res_word.status = ffca_pkg::ST_NOTFOUND;
            end
        end
        else if (req_zero || !best_found_reg)
        begin
            res_word.status = ffca_pkg::ST_NOSPACE;
        end
        else if (exact_fit)
        begin
            res_word.result_addr = best_start_reg;
        end
        else if (!slot_found_reg)
        begin
            res_word.status = ffca_pkg::ST_FULL;
        end
        else
        begin
            res_word.result_addr = best_start_reg;
            need_split           = 1'b1;
        end
    end

    // flag updates
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        if (cfg_we)
        begin
            valid_next    = '0;
            valid_next[0] = 1'b1;
            used_next     = '0;
        end
        else if (cmd.decide && best_found_reg && (res_word.status == ffca_pkg::ST_OK))
        begin
            if (op_reg == ffca_pkg::OP_FREE)
            begin
                used_next[best_idx_reg] = 1'b0;
            end
            else if (!need_split)
            begin
                used_next[best_idx_reg] = 1'b1;
            end
        end
        else if (cmd.write_slot)
        begin
            valid_next[slot_idx_reg] = 1'b1;
            used_next[slot_idx_reg]  = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_total_reg   <= ffca_pkg::HEAP_MAX;
            init_pending_reg <= 1'b1;
            valid_reg        <= ENTRIES'(1);
            used_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            if (cfg_we)
            begin
                heap_total_reg   <= cfg_wdata;
                init_pending_reg <= 1'b1;
            end
            else if (cmd.init_write)
            begin
                init_pending_reg <= 1'b0;
            end
            rd_vld_reg <= cmd.scan_step;
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, scan tracking and result payload
    always_ff @(posedge clk)
    begin
        rd_tag_reg <= scan_idx_reg;
        if (cmd.scan_start)
        begin
            op_reg         <= req_word.op;
            req_reg        <= req_word.req_size;
            addr_reg       <= req_word.release_addr;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            slot_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (take)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= rd_tag_reg;
                best_start_reg <= ram_rdata.start;
                best_size_reg  <= ram_rdata.size;
            end
            if (rd_vld_reg && !rd_v && !slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
                slot_idx_reg   <= rd_tag_reg;
            end
        end
        // the decision inputs hold still until the reply is loaded
        if (cmd.load_out)
        begin
            rsp_word_reg <= res_word;
        end
    end

    // status to the controller
    assign sts.init_pending = init_pending_reg;
    assign sts.scan_last    = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.need_split   = need_split;
    assign sts.out_free     = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // response register is never overwritten while it holds a waiting word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before it was taken");

    // a split lands only in an entry that was found invalid, outside the table
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_slot |-> (slot_found_reg && !valid_reg[slot_idx_reg]))
        else $error("split written into a valid entry");

    // shrinking the old chunk directly follows making the new entry
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_best |-> $past(cmd.write_slot))
        else $error("chunk shrunk without a new entry");

    // entry zero always stays part of the table
    a_entry0: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0])
        else $error("entry zero lost its valid bit");

endmodule

/* hdl/ffca_ctrl.sv */
// request sequencing state machine
module ffca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ffca_pkg::dp_status_t sts,
    output ffca_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_SLOT   = 7'b0100000,
        S_REPLY  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready;
    logic   shrink_reg, shrink_next;

    assign in_ready  = (state_reg == S_IDLE) && !sts.init_pending;
    assign req_ready = in_ready;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        shrink_next = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_write = 1'b1;
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                if (sts.init_pending)
                begin
                    state_next = S_INIT;
                end
                else if (req_valid)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_split ? S_SLOT : S_REPLY;
            end
            S_SLOT:
            begin
                cmd.write_slot = 1'b1;
                shrink_next    = 1'b1;
                state_next     = S_REPLY;
            end
            S_REPLY:
            begin
                // shrink the old chunk on the first reply cycle after a split
                cmd.write_best = shrink_reg;
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            shrink_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            shrink_reg <= shrink_next;
        end
    end

endmodule

/* hdl/first_fit_chunk_allocator.sv */
// top level of the first-fit chunk allocator
//
//  channel   handshake            word           contents
//  request   req_valid/req_ready  req_word       op, req_size, release_addr
//  response  rsp_valid/rsp_ready  rsp_word       result_addr, status
//  config    cfg_we               cfg_wdata      heap size in bytes, no wait
//
// every request scans the whole chunk table memory at one entry a cycle,
// waits for the registered read data, decides, splits if needed, replies
// after reset and after a heap size write, entry zero is written with the
// whole heap in the init state before the next request is taken
// a waiting response holds the block in its reply cycle until it is taken
module first_fit_chunk_allocator #(
    parameter int ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffca_pkg::in_word_t             req_word,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffca_pkg::out_word_t            rsp_word,
    input  logic                           cfg_we,
    input  logic [ffca_pkg::SIZE_BITS-1:0] cfg_wdata
);

    ffca_pkg::ctrl_cmd_t  cmd;
    ffca_pkg::dp_status_t sts;

    // sequencing
    ffca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table and result path
    ffca_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_word  (req_word),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule
